// ===== hdl/tuuid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuuid_pkg
// Shared types and constants for the time-based UUID generator.
// ----------------------------------------------------------------------------
package tuuid_pkg;

    localparam int TICKS_W  = 63;
    localparam int TIME_W   = 64;
    localparam int CNT_W    = 10;
    localparam int SEQ_W    = 13;
    localparam int NODE_W   = 48;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 128;

    // 15 Oct 1582 to 1 Jan 1601 in 100 ns ticks
    localparam logic [TIME_W-1:0] EPOCH_OFFSET =
        TIME_W'(64'd6653 * 64'd86400 * 64'd10000000);

    // largest same-tick count; stamps within one tick use counts 0 up to it
    localparam logic [CNT_W-1:0] SAME_TICK_LIMIT = 10'd1000;

    localparam logic [3:0] UUID_VERSION = 4'h1;
    localparam logic [1:0] UUID_VARIANT = 2'b10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDRESS   = 2'd0,
        CFG_SEQUENCE_SEED  = 2'd1,
        CFG_NODE_IS_RANDOM = 2'd2
    } t_cfg_idx;

endpackage

// ===== hdl/time_based_uuid_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_based_uuid_generator
// Version-1 UUID field generator: timestamp plus same-tick count, clock
// sequence and configured node.
// ----------------------------------------------------------------------------
// Takes one time sample per cycle on the slave stream unless stalled, and
// returns the UUID fields on the master stream through the input register,
// which adds the epoch offset, and the output register, fed by compare/pack
// logic that updates the last time, the same-tick count and the clock
// sequence. The first item after reset only primes that state and gives no
// result; an item repeating the last time after the same-tick count has
// reached its limit is also dropped. Back-pressure on the master side stalls
// the input only when the output register is full and the pending item would
// produce a result. Configuration is meant to change only while idle.
module time_based_uuid_generator
    import tuuid_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [NODE_W-1:0]      i_cfg_wdata,
    // time samples
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [62:0] time_ticks
    // UUID fields
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] time_low, [47:32] time_mid, [63:48] time_hi_version,
    // [71:64] clock_seq_hi_variant, [79:72] clock_seq_low, [127:80] node
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]             m_axis_tuser    // [0] local_only
);

    // configuration
    logic [NODE_W-1:0] r_node;
    logic [SEQ_W-1:0]  r_seed;
    logic              r_rand;

    // input stage
    logic              r_s1_valid;
    logic [TIME_W-1:0] r_s1_now;

    // generator state
    logic              r_started;
    logic [TIME_W-1:0] r_last_time;
    logic [CNT_W-1:0]  r_cnt;
    logic [SEQ_W-1:0]  r_seq;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_local;

    logic              n_emit;
    logic [CNT_W-1:0]  n_cnt;
    logic [SEQ_W-1:0]  n_seq;
    logic [TIME_W-1:0] stamp;
    logic              out_free;
    logic              proc;
    logic              in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_seed <= '0;
            r_rand <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NODE_ADDRESS:   r_node <= i_cfg_wdata;
                CFG_SEQUENCE_SEED:  r_seed <= i_cfg_wdata[SEQ_W-1:0];
                CFG_NODE_IS_RANDOM: r_rand <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // decide what the pending item does to the state
    always_comb begin
        n_emit = 1'b0;
        n_cnt  = r_cnt;
        n_seq  = r_seq;
        if (!r_started) begin
            n_cnt = SAME_TICK_LIMIT;
            n_seq = r_seed;
        end else if (r_s1_now > r_last_time) begin
            n_cnt  = '0;
            n_emit = 1'b1;
        end else if (r_s1_now < r_last_time) begin
            // clock went backwards
            n_seq  = r_seq + SEQ_W'(1);
            n_cnt  = '0;
            n_emit = 1'b1;
        end else if (r_cnt < SAME_TICK_LIMIT) begin
            n_cnt  = r_cnt + CNT_W'(1);
            n_emit = 1'b1;
        end
    end

    assign stamp     = r_s1_now + TIME_W'(n_cnt);
    assign out_free  = !r_out_valid || m_axis_tready;
    assign proc      = r_s1_valid && (!n_emit || out_free);
    assign s_axis_tready = !r_s1_valid || proc;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_now <= TIME_W'(s_axis_tdata[TICKS_W-1:0]) + EPOCH_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_last_time <= '0;
            r_cnt       <= '0;
            r_seq       <= '0;
        end else if (proc) begin
            r_started   <= 1'b1;
            r_last_time <= r_s1_now;
            r_cnt       <= n_cnt;
            r_seq       <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_emit) begin
            r_out_data  <= {r_node,
                            n_seq[7:0],
                            UUID_VARIANT, 1'b0, n_seq[SEQ_W-1:8],
                            UUID_VERSION, stamp[59:48],
                            stamp[47:32],
                            stamp[31:0]};
            r_out_local <= r_rand;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_local;

endmodule

// ===== hdl/tuuid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuuid_checker
// Port-level checks for the time-based UUID generator.
// ----------------------------------------------------------------------------
module tuuid_checker
    import tuuid_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [NODE_W-1:0]      i_cfg_wdata,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    // shadow of the node configuration as seen on the port
    logic [NODE_W-1:0] r_node;
    logic              r_rand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_rand <= 1'b0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_NODE_ADDRESS) begin
                r_node <= i_cfg_wdata;
            end
            if (i_cfg_index == CFG_NODE_IS_RANDOM) begin
                r_rand <= i_cfg_wdata[0];
            end
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("result valid or input not ready after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");

    a_version_variant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:60] == UUID_VERSION
                          && m_axis_tdata[71:69] == {UUID_VARIANT, 1'b0})
        else $error("bad version or variant bits");

    a_node_matches_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[127:80] == r_node && m_axis_tuser[0] == r_rand)
        else $error("node or local flag differs from configuration");

endmodule

bind time_based_uuid_generator tuuid_checker u_tuuid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_wdata   (i_cfg_wdata),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/time_based_uuid_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_based_uuid_generator_tb
// Self-checking bench for the version-1 UUID field generator.
// ----------------------------------------------------------------------------
// Streams time samples into the block and scores every UUID item against a
// cycle-free model of the last-time / same-tick / clock-sequence state. A
// short table covers priming, the same-tick limit, sequence wrap and the
// extremes of the time field; random well-formed time walks follow, plus one
// long equal-time run that drives the same-tick count to its limit. Both
// stream sides idle at random and the receiver stalls once for a long time.
// ----------------------------------------------------------------------------
module time_based_uuid_generator_tb;
    import tuuid_pkg::*;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [TICKS_W-1:0]   TICKS_MAX  = '1;
    localparam int  DIR_ROWS = 19;

    typedef struct packed {
        logic [31:0]       time_low;
        logic [15:0]       time_mid;
        logic [15:0]       time_hi_version;
        logic [7:0]        seq_hi_variant;
        logic [7:0]        seq_low;
        logic [NODE_W-1:0] node;
        logic              local_only;
    } t_uuid;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_TYPED} t_row_kind;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        t_row_kind          kind;
        logic [TIME_W-1:0]  stamp;  // typed rows only
        logic [SEQ_W-1:0]   seq;    // typed rows only
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [NODE_W-1:0]      i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [62:0] time_ticks
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] time_low, [47:32] time_mid, [63:48] time_hi_version,
    // [71:64] clock_seq_hi_variant, [79:72] clock_seq_low, [127:80] node
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;        // [0] local_only

    time_based_uuid_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state and shadow configuration
    logic [TIME_W-1:0] prev_time = '0;
    logic [CNT_W-1:0]  tick_count = '0;
    logic [SEQ_W-1:0]  clock_seq = '0;
    bit                primed = 1'b0;
    logic [NODE_W-1:0] node_addr = '0;
    logic [SEQ_W-1:0]  seq_seed = '0;
    logic              node_random = 1'b0;

    t_uuid pending_uuids[$];
    int    mismatches = 0;
    int    uuids_seen = 0;
    int    src_idle_pct = 0;
    int    snk_idle_pct = 0;
    int    cycles = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;

    function automatic t_uuid uuid_fields(input logic [TIME_W-1:0] stamp,
                                          input logic [SEQ_W-1:0] seq);
        t_uuid u;
        u.time_low        = stamp[31:0];
        u.time_mid        = stamp[47:32];
        u.time_hi_version = {UUID_VERSION, stamp[59:48]};
        u.seq_hi_variant  = {UUID_VARIANT, 6'(seq[12:8])};
        u.seq_low         = seq[7:0];
        u.node            = node_addr;
        u.local_only      = node_random;
        return u;
    endfunction

    // returns 1 when the sample yields a UUID
    function automatic bit predict_uuid(input logic [TICKS_W-1:0] ticks,
                                        output t_uuid u);
        logic [TIME_W-1:0] now_t;
        now_t = {1'b0, ticks} + EPOCH_OFFSET;
        u = '0;
        if (!primed) begin
            primed     = 1'b1;
            prev_time  = now_t;
            clock_seq  = seq_seed;
            tick_count = SAME_TICK_LIMIT;
            return 1'b0;
        end
        if (now_t > prev_time) begin
            tick_count = '0;
        end else if (now_t < prev_time) begin
            clock_seq  = clock_seq + 1'b1;
            tick_count = '0;
        end else if (tick_count < SAME_TICK_LIMIT) begin
            tick_count = tick_count + 1'b1;
        end else begin
            return 1'b0;
        end
        prev_time = now_t;
        u = uuid_fields(now_t + TIME_W'(tick_count), clock_seq);
        return 1'b1;
    endfunction

    // mostly small steps around the last time so equal/earlier cases are common
    function automatic logic [TICKS_W-1:0] next_ticks(input logic [TICKS_W-1:0] prev);
        int unsigned       roll;
        logic [TICKS_W-1:0] step;
        roll = $urandom_range(0, 99);
        step = TICKS_W'($urandom_range(1, 5000));
        if (roll < 45)
            return prev;
        else if (roll < 75)
            return prev + step;
        else if (roll < 85)
            return prev - step;
        else if (roll < 95)
            return TICKS_W'({$urandom, $urandom});
        else
            return roll[0] ? TICKS_MAX : '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [NODE_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_NODE_ADDRESS:   node_addr = val;
            CFG_SEQUENCE_SEED:  seq_seed = val[SEQ_W-1:0];
            CFG_NODE_IS_RANDOM: node_random = val[0];
            default: ;
        endcase
    endtask

    task automatic offer_ticks(input logic [TICKS_W-1:0] ticks);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ticks};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_ticks(input logic [TICKS_W-1:0] ticks);
        t_uuid u;
        offer_ticks(ticks);
        if (predict_uuid(ticks, u))
            pending_uuids.push_back(u);
    endtask

    // dropped samples may still be in flight after the last UUID arrives
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_uuids.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver: scoring, random idling and one long hold-off
    always @(posedge i_clk) begin
        t_uuid got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.time_low        = m_axis_tdata[31:0];
            got.time_mid        = m_axis_tdata[47:32];
            got.time_hi_version = m_axis_tdata[63:48];
            got.seq_hi_variant  = m_axis_tdata[71:64];
            got.seq_low         = m_axis_tdata[79:72];
            got.node            = m_axis_tdata[127:80];
            got.local_only      = m_axis_tuser[0];
            uuids_seen++;
            if (pending_uuids.size() == 0) begin
                report_mismatch("unexpected item, time_low", 64'(got.time_low), '0);
            end else begin
                want = pending_uuids.pop_front();
                if (got.time_low !== want.time_low)
                    report_mismatch("time_low", 64'(got.time_low), 64'(want.time_low));
                if (got.time_mid !== want.time_mid)
                    report_mismatch("time_mid", 64'(got.time_mid), 64'(want.time_mid));
                if (got.time_hi_version !== want.time_hi_version)
                    report_mismatch("time_hi_version", 64'(got.time_hi_version),
                                    64'(want.time_hi_version));
                if (got.seq_hi_variant !== want.seq_hi_variant)
                    report_mismatch("clock_seq_hi_variant", 64'(got.seq_hi_variant),
                                    64'(want.seq_hi_variant));
                if (got.seq_low !== want.seq_low)
                    report_mismatch("clock_seq_low", 64'(got.seq_low), 64'(want.seq_low));
                if (got.node !== want.node)
                    report_mismatch("node", 64'(got.node), 64'(want.node));
                if (got.local_only !== want.local_only)
                    report_mismatch("local_only", 64'(got.local_only), 64'(want.local_only));
            end
        end
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && uuids_seen >= 450) begin
            // long stall while the sender keeps offering: fills the pipe
            m_axis_tready <= 1'b0;
            hold_left = 300;
            hold_done = 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_dir_row          dir_rows [DIR_ROWS];
        logic [TICKS_W-1:0] cur_ticks;
        t_uuid             want;
        bit                has_uuid;

        // seed is set to all ones below, so earlier times wrap the sequence
        dir_rows = '{
            '{63'd0, ROW_NONE, 64'd0, 13'd0},            // primes, count at limit
            '{63'd0, ROW_NONE, 64'd0, 13'd0},            // equal time at limit: dropped
            '{63'd1, ROW_TYPED, EPOCH_OFFSET + 64'd1, 13'h1FFF},
            '{63'd0, ROW_TYPED, EPOCH_OFFSET, 13'h0000}, // earlier: sequence wraps
            '{63'd0, ROW_PREDICT, 64'd0, 13'd0},
            '{63'd0, ROW_PREDICT, 64'd0, 13'd0},
            '{TICKS_MAX, ROW_TYPED, EPOCH_OFFSET + {1'b0, TICKS_MAX}, 13'h0000},
            '{TICKS_MAX, ROW_PREDICT, 64'd0, 13'd0},
            '{TICKS_MAX - 1'b1, ROW_TYPED, EPOCH_OFFSET + {1'b0, TICKS_MAX} - 64'd1, 13'h0001},
            '{63'h2AAA_AAAA_AAAA_AAAA, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h5555_5555_5555_5555, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h5555_5555_5555_5555, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h0000_0000_FFFF_FFFF, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h0000_0001_0000_0000, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h0FFF_FFFF_FFFF_FFFF, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h7000_0000_0000_0000, ROW_PREDICT, 64'd0, 13'd0},
            '{63'h7000_0000_0000_0000, ROW_PREDICT, 64'd0, 13'd0},
            '{63'd1, ROW_PREDICT, 64'd0, 13'd0},
            '{63'd2, ROW_PREDICT, 64'd0, 13'd0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(CFG_UNUSED, NODE_W'({$urandom, $urandom}));
        cfg_write(CFG_SEQUENCE_SEED, '0);
        cfg_write(CFG_SEQUENCE_SEED, NODE_W'({$urandom, 13'h1FFF}));
        cfg_write(CFG_NODE_ADDRESS, '1);
        cfg_write(CFG_NODE_IS_RANDOM, NODE_W'({$urandom, 1'b1}));
        i_cfg_wr_en <= 1'b0;

        src_idle_pct = 23;
        snk_idle_pct = 23;
        foreach (dir_rows[i]) begin
            offer_ticks(dir_rows[i].ticks);
            has_uuid = predict_uuid(dir_rows[i].ticks, want);
            if (dir_rows[i].kind == ROW_NONE) begin
                if (has_uuid)
                    report_mismatch("table row expects no item", 64'(i), '0);
            end else begin
                if (!has_uuid)
                    report_mismatch("table row expects an item", 64'(i), '0);
                if (dir_rows[i].kind == ROW_TYPED)
                    want = uuid_fields(dir_rows[i].stamp, dir_rows[i].seq);
                pending_uuids.push_back(want);
            end
        end
        cur_ticks = dir_rows[DIR_ROWS-1].ticks;
        wait_drained();

        // seed writes after priming must not matter
        cfg_write(CFG_NODE_ADDRESS, '0);
        cfg_write(CFG_NODE_IS_RANDOM, NODE_W'({$urandom, 1'b0}));
        cfg_write(CFG_SEQUENCE_SEED, NODE_W'({$urandom, $urandom}));
        i_cfg_wr_en <= 1'b0;

        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int n = 0; n < 60; n++) begin
            if (n == 30) begin
                src_idle_pct = 23;
                snk_idle_pct = 23;
            end
            cur_ticks = next_ticks(cur_ticks);
            send_ticks(cur_ticks);
        end
        wait_drained();

        cfg_write(CFG_NODE_ADDRESS, NODE_W'({$urandom, $urandom}));
        cfg_write(CFG_NODE_IS_RANDOM, NODE_W'($urandom_range(0, 1)));
        cfg_write(CFG_UNUSED, NODE_W'({$urandom, $urandom}));
        i_cfg_wr_en <= 1'b0;

        for (int n = 0; n < 40; n++) begin
            cur_ticks = next_ticks(cur_ticks);
            send_ticks(cur_ticks);
        end
        wait_drained();

        cfg_write(CFG_NODE_ADDRESS, NODE_W'({$urandom, $urandom}));
        cfg_write(CFG_NODE_IS_RANDOM, NODE_W'({$urandom, 1'b1}));
        i_cfg_wr_en <= 1'b0;

        // one time held long enough to walk the same-tick count to its limit,
        // with no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        cur_ticks = TICKS_W'({$urandom, $urandom});
        for (int n = 0; n < 1003; n++)
            send_ticks(cur_ticks);
        wait_drained();
        src_idle_pct = 23;
        snk_idle_pct = 23;

        cfg_write(CFG_NODE_ADDRESS, NODE_W'({$urandom, $urandom}));
        cfg_write(CFG_NODE_IS_RANDOM, '0);
        cfg_write(CFG_SEQUENCE_SEED, NODE_W'({$urandom, $urandom}));
        i_cfg_wr_en <= 1'b0;

        for (int n = 0; n < 30; n++) begin
            cur_ticks = next_ticks(cur_ticks);
            send_ticks(cur_ticks);
        end
        wait_drained();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
